// ----- hw/rtl/sdfb_pkg.sv -----
// Shared types and constants for the SPI display frame buffer.
// No dependencies; imported by every module of the block.
`default_nettype none

package sdfb_pkg;

   // item kinds on the request channel
   localparam logic KIND_PINS  = 1'b0;
   localparam logic KIND_PIXEL = 1'b1;

   localparam logic [31:0] COLOR_SET   = 32'hFF00FFFF;
   localparam logic [31:0] COLOR_CLEAR = 32'hFF000000;

   // side information that travels with a pixel read next to the memory read
   typedef struct packed {
      logic       in_range;  // pixel lies inside the display and the buffer
      logic       written;   // byte has been written since reset
      logic [2:0] bit_sel;   // row within the page
   } pix_meta_type;

endpackage

`default_nettype wire

// ----- hw/rtl/sdfb_spi_rx.sv -----
// SPI receive side: clock edge tracking, byte assembly and write address.
// Depends on sdfb_pkg.
`default_nettype none

module sdfb_spi_rx import sdfb_pkg::*; #(
   parameter int BUFFER_BYTES = 1024,
   parameter int AW           = $clog2(BUFFER_BYTES)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          pin_take,     // pin beat while selected in data phase
   input  wire logic          serial_data,
   input  wire logic          serial_clock,
   output logic               wr_en,
   output logic [AW-1:0]      wr_addr,
   output logic [7:0]         wr_data,
   output logic [AW-1:0]      fill_addr,    // next byte to be written
   output logic               fill_wrapped  // whole buffer written at least once
);

   logic [7:0]    shift_ff, shift_in;
   logic [2:0]    bitpos_ff, bitpos_in;
   logic          prev_clk_ff, prev_clk_in;
   logic [AW-1:0] waddr_ff, waddr_in;
   logic          wrapped_ff, wrapped_in;
   logic          rise;
   logic [7:0]    merged;

   assign rise   = pin_take && !prev_clk_ff && serial_clock;
   assign merged = shift_ff | (8'(serial_data) << bitpos_ff);

   always_comb begin
      shift_in    = shift_ff;
      bitpos_in   = bitpos_ff;
      prev_clk_in = prev_clk_ff;
      waddr_in    = waddr_ff;
      wrapped_in  = wrapped_ff;
      wr_en       = 1'b0;
      if (rise) begin
         prev_clk_in = 1'b1;
         if (bitpos_ff == 3'd0) begin
            wr_en     = 1'b1;
            bitpos_in = 3'd7;
            shift_in  = 8'd0;
            if (waddr_ff == AW'(BUFFER_BYTES - 1)) begin
               waddr_in   = '0;
               wrapped_in = 1'b1;
            end else begin
               waddr_in = waddr_ff + AW'(1);
            end
         end else begin
            bitpos_in = bitpos_ff - 3'd1;
            shift_in  = merged;
         end
      end else if (pin_take && !serial_clock) begin
         prev_clk_in = 1'b0;
      end
   end

   assign wr_addr      = waddr_ff;
   assign wr_data      = merged;
   assign fill_addr    = waddr_ff;
   assign fill_wrapped = wrapped_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff    <= 8'd0;
         bitpos_ff   <= 3'd7;
         prev_clk_ff <= 1'b0;
         waddr_ff    <= '0;
         wrapped_ff  <= 1'b0;
      end else begin
         shift_ff    <= shift_in;
         bitpos_ff   <= bitpos_in;
         prev_clk_ff <= prev_clk_in;
         waddr_ff    <= waddr_in;
         wrapped_ff  <= wrapped_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/sdfb_frame_mem.sv -----
// Frame byte store: one write port, one read port with registered data.
// Depends on sdfb_pkg.
`default_nettype none

module sdfb_frame_mem import sdfb_pkg::*; #(
   parameter int BUFFER_BYTES = 1024,
   parameter int AW           = $clog2(BUFFER_BYTES)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic [7:0]         rd_data
);

   logic [7:0] mem [BUFFER_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/sdfb_pixel_out.sv -----
// Pixel read tail: read stage tracking, bit pick, color word and output register.
// Depends on sdfb_pkg.
`default_nettype none

module sdfb_pixel_out import sdfb_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         rd_issue,     // pixel read beat accepted this cycle
   input  wire pix_meta_type rd_meta,
   input  wire logic [7:0]   rd_data,      // registered memory data for stage 1
   output logic              stage_free,   // a new beat may be accepted
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [31:0]       rsp_pixel_color
);

   logic         s1_valid_ff, s1_valid_in;
   pix_meta_type s1_meta_ff;
   logic         out_valid_ff, out_valid_in;
   logic [31:0]  out_color_ff;
   logic         out_free, s1_move, pix_set;

   assign out_free   = !out_valid_ff || rsp_ready;
   assign s1_move    = s1_valid_ff && out_free;
   assign stage_free = !s1_valid_ff || out_free;

   assign pix_set = s1_meta_ff.in_range && s1_meta_ff.written
                    && rd_data[s1_meta_ff.bit_sel];

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      if (rd_issue) begin
         s1_valid_in = 1'b1;
      end
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_issue) begin
         s1_meta_ff <= rd_meta;
      end
      if (s1_move) begin
         out_color_ff <= pix_set ? COLOR_SET : COLOR_CLEAR;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pixel_color = out_color_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/spi_display_frame_buffer_top.sv -----
// SPI display frame buffer: takes one beat per cycle, pin sample or pixel read,
// while req_ready is high. Pin samples produce no response; a pixel read passes
// the frame memory data register, then the output register held by rsp_ready.
// Reset clears the receiver state; bytes not written since reset read as zero,
// tracked by the write address and a wrap flag, so no clearing pass is run.
// Depends on sdfb_pkg, sdfb_spi_rx, sdfb_frame_mem, sdfb_pixel_out.
`default_nettype none

module spi_display_frame_buffer_top import sdfb_pkg::*; #(
   parameter int COLUMNS      = 128,
   parameter int ROWS         = 64,
   parameter int BUFFER_BYTES = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_kind,
   input  wire logic        req_chip_select,
   input  wire logic        req_serial_data,
   input  wire logic        req_serial_clock,
   input  wire logic        req_data_not_command,
   input  wire logic [6:0]  req_pixel_x,
   input  wire logic [5:0]  req_pixel_y,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_pixel_color
);

   localparam int AW = $clog2(BUFFER_BYTES);
   localparam int CW = 16;

   logic          req_beat, pin_take, rd_issue, stage_free;
   logic          wr_en, fill_wrapped;
   logic [AW-1:0] wr_addr, fill_addr, rd_addr;
   logic [7:0]    wr_data, rd_data;
   logic [CW-1:0] byte_addr;
   pix_meta_type  rd_meta;

   assign req_ready = stage_free;
   assign req_beat  = req_valid && req_ready;
   assign pin_take  = req_beat && (req_kind == KIND_PINS)
                      && !req_chip_select && req_data_not_command;
   assign rd_issue  = req_beat && (req_kind == KIND_PIXEL);

   // byte address = column + page * COLUMNS
   assign byte_addr = CW'(req_pixel_x) + CW'(req_pixel_y[5:3]) * CW'(COLUMNS);
   assign rd_addr   = byte_addr[AW-1:0];

   always_comb begin
      rd_meta.in_range = (CW'(req_pixel_x) < CW'(COLUMNS))
                         && (CW'(req_pixel_y) < CW'(ROWS))
                         && (byte_addr < CW'(BUFFER_BYTES));
      rd_meta.written  = fill_wrapped || (rd_addr < fill_addr);
      rd_meta.bit_sel  = req_pixel_y[2:0];
   end

   sdfb_spi_rx #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .AW           (AW)
   ) u_spi_rx (
      .clock        (clock),
      .reset        (reset),
      .pin_take     (pin_take),
      .serial_data  (req_serial_data),
      .serial_clock (req_serial_clock),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .fill_addr    (fill_addr),
      .fill_wrapped (fill_wrapped)
   );

   sdfb_frame_mem #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .AW           (AW)
   ) u_frame_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sdfb_pixel_out u_pixel_out (
      .clock           (clock),
      .reset           (reset),
      .rd_issue        (rd_issue),
      .rd_meta         (rd_meta),
      .rd_data         (rd_data),
      .stage_free      (stage_free),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_color (rsp_pixel_color)
   );

endmodule

`default_nettype wire
